FILE: src/cpl_pkg.sv
// Package for the callsign prefix lookup: operation and status codes,
// state machine type, bucket decode and key-width helpers. No dependencies.
package cpl_pkg;

   localparam int DefTableDepth    = 4096;
   localparam int DefKeyChars      = 16;
   localparam int DefEntityCount   = 1024;
   localparam int DefOverrideCount = 1024;
   localparam int Buckets          = 36;
   localparam int BucketBits       = 6;

   typedef enum logic [2:0] {
      OP_WR_EXACT = 3'd0,
      OP_WR_FWD   = 3'd1,
      OP_RG_EXACT = 3'd2,
      OP_RG_FWD   = 3'd3,
      OP_LOOKUP   = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_DONE    = 3'd0,
      ST_EXACT   = 3'd1,
      ST_FWD     = 3'd2,
      ST_MISS    = 3'd3,
      ST_INVALID = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RANGE,
      S_EX_ISSUE,
      S_EX_CHECK,
      S_FW_ISSUE,
      S_FW_CHECK,
      S_REPLY
   } fsm_type;

   // mask keeping the top n bytes of a 64-bit word
   function automatic logic [63:0] top_bytes(input logic [4:0] n);
      logic [63:0] m;
      m = '0;
      for (int b = 0; b < 8; b++) begin
         if (5'(b) < n) m[63-8*b -: 8] = 8'hFF;
      end
      return m;
   endfunction

   function automatic logic bucket_ok(input logic [7:0] ch);
      return (ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h41 && ch <= 8'h5A);
   endfunction

   function automatic logic [BucketBits-1:0] bucket_of(input logic [7:0] ch);
      logic [7:0] b;
      b = (ch <= 8'h39) ? (ch - 8'h30) : (ch - 8'h41 + 8'd10);
      return b[BucketBits-1:0];
   endfunction

endpackage

FILE: src/cpl_if.sv
// Valid/ready channel interfaces for request and response transfers.
// Depends on nothing but the widths given as parameters.
interface cpl_req_if #(
   parameter int SlotW = 12,
   parameter int EntW  = 10,
   parameter int OvrW  = 10
);
   logic             valid;
   logic             ready;
   logic [2:0]       op;
   logic [SlotW-1:0] slot;
   logic [63:0]      key_hi;
   logic [63:0]      key_lo;
   logic [4:0]       prefix_length;
   logic [EntW-1:0]  entity_number;
   logic             has_override;
   logic [OvrW-1:0]  override_number;
   logic [SlotW-1:0] range_first;
   logic [SlotW-1:0] range_last;
   logic             range_present;
   modport source (output valid, op, slot, key_hi, key_lo, prefix_length, entity_number,
                   has_override, override_number, range_first, range_last, range_present,
                   input ready);
   modport sink (input valid, op, slot, key_hi, key_lo, prefix_length, entity_number,
                 has_override, override_number, range_first, range_last, range_present,
                 output ready);
endinterface

interface cpl_rsp_if #(
   parameter int SlotW = 12,
   parameter int EntW  = 10,
   parameter int OvrW  = 10
);
   logic             valid;
   logic             ready;
   logic [2:0]       status;
   logic [SlotW-1:0] entry_found;
   logic [EntW-1:0]  entity_found;
   logic             override_found;
   logic [OvrW-1:0]  override_index;
   modport source (output valid, status, entry_found, entity_found, override_found,
                   override_index, input ready);
   modport sink (input valid, status, entry_found, entity_found, override_found,
                 override_index, output ready);
endinterface

FILE: src/callsign_prefix_lookup.sv
// Callsign prefix lookup top level: key tables in synchronous memories,
// bucket range registers and the search sequencer. Uses cpl_pkg, cpl_if.
//
// Usage: items arrive on req (valid/ready); each gives exactly one transfer
// on rsp. Ops 0-1 write a table entry, ops 2-3 write a bucket range, op 4
// looks a key up; other ops change nothing. A write, a spare op or a bad
// first character raises rsp.valid in the cycle after the request transfer.
// A lookup reads the bucket ranges, then binary-searches the exact range,
// each probe being one memory read and then one compare; an exact hit ends
// the search. An absent or exhausted exact range leads to a scan of the
// forward entries in order, one read and one compare each, and a scan that
// ends without a hit gives a miss. A 4096-entry bucket needs at most 13
// probes. Each memory has a single read port. One item is worked on at a
// time; req.ready is low during reset, while a lookup runs and while a
// response waits, and the next request can transfer in the cycle after the
// response transfer at the earliest. A stalled rsp holds the response and
// blocks the next request. Reset clears the sequencer and marks all 72
// bucket ranges empty at once; table memories are not cleared and no entry
// may be looked up before it is written.
module callsign_prefix_lookup
   import cpl_pkg::*;
#(
   parameter int TABLE_DEPTH    = DefTableDepth,
   parameter int KEY_CHARS      = DefKeyChars
) (
   input logic     clock,
   input logic     reset,
   cpl_req_if.sink   req,
   cpl_rsp_if.source rsp
);
   localparam int SlotW = 12;
   localparam int AddrW = $clog2(TABLE_DEPTH);
   localparam int EntW  = $clog2(DefEntityCount);
   localparam int OvrW  = $clog2(DefOverrideCount);
   localparam int PayW  = EntW + 1 + OvrW;
   localparam int IdxW  = ((AddrW > SlotW) ? AddrW : SlotW) + 1;
   localparam logic [4:0] HiChars = 5'((KEY_CHARS < 8) ? KEY_CHARS : 8);
   localparam logic [4:0] LoChars = 5'((KEY_CHARS > 8) ? KEY_CHARS - 8 : 0);
   localparam logic [4:0] KeyCh   = 5'(KEY_CHARS);
   localparam logic signed [IdxW:0] IdxOne = 1;

   // memories
   logic [63:0]     ex_hi_mem [TABLE_DEPTH];
   logic [63:0]     ex_lo_mem [TABLE_DEPTH];
   logic [PayW-1:0] ex_pay_mem [TABLE_DEPTH];
   logic [63:0]     fw_hi_mem [TABLE_DEPTH];
   logic [63:0]     fw_lo_mem [TABLE_DEPTH];
   logic [4:0]      fw_len_mem [TABLE_DEPTH];
   logic [PayW-1:0] fw_pay_mem [TABLE_DEPTH];

   logic [63:0]     ex_hi_rd, ex_lo_rd, fw_hi_rd, fw_lo_rd;
   logic [PayW-1:0] ex_pay_rd, fw_pay_rd;
   logic [4:0]      fw_len_rd;

   // bucket ranges: present flag, first, last
   logic [Buckets-1:0] ex_pr_ff, fw_pr_ff;
   logic [SlotW-1:0]   ex_first_ff [Buckets];
   logic [SlotW-1:0]   ex_last_ff  [Buckets];
   logic [SlotW-1:0]   fw_first_ff [Buckets];
   logic [SlotW-1:0]   fw_last_ff  [Buckets];
   logic [SlotW-1:0]   ex_first_rd, ex_last_rd, fw_first_rd, fw_last_rd;

   fsm_type state_ff, state_in;
   logic [63:0]       khi_ff, klo_ff;
   logic [BucketBits-1:0] bkt_ff;
   logic signed [IdxW:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [AddrW-1:0]  addr_ff, addr_in;

   logic              rvalid_ff;
   status_type        rstat_ff, rstat_in;
   logic [SlotW-1:0]  rentry_ff, rentry_in;
   logic [PayW-1:0]   rpay_ff, rpay_in;
   logic              load_rsp;

   logic accept;
   op_type op;
   logic [63:0] khi_m, klo_m;

   assign op     = op_type'(req.op);
   assign accept = req.valid && req.ready;
   assign khi_m  = req.key_hi & top_bytes(HiChars);
   assign klo_m  = req.key_lo & top_bytes(LoChars);
   assign req.ready = !reset && (state_ff == S_IDLE) && !rvalid_ff;

   logic slot_in_table;
   assign slot_in_table = (32'(req.slot) < 32'(TABLE_DEPTH));
   logic [AddrW-1:0] wr_addr;
   assign wr_addr = AddrW'(req.slot);
   logic [PayW-1:0] wr_pay;
   assign wr_pay = {req.override_number[OvrW-1:0], req.has_override,
                    req.entity_number[EntW-1:0]};

   always_ff @(posedge clock) begin
      if (accept && op == OP_WR_EXACT && slot_in_table) begin
         ex_hi_mem[wr_addr]  <= khi_m;
         ex_lo_mem[wr_addr]  <= klo_m;
         ex_pay_mem[wr_addr] <= wr_pay;
      end
      ex_hi_rd  <= ex_hi_mem[addr_in];
      ex_lo_rd  <= ex_lo_mem[addr_in];
      ex_pay_rd <= ex_pay_mem[addr_in];
   end

   always_ff @(posedge clock) begin
      if (accept && op == OP_WR_FWD && slot_in_table) begin
         fw_hi_mem[wr_addr]  <= khi_m;
         fw_lo_mem[wr_addr]  <= klo_m;
         fw_len_mem[wr_addr] <= req.prefix_length;
         fw_pay_mem[wr_addr] <= wr_pay;
      end
      fw_hi_rd  <= fw_hi_mem[addr_in];
      fw_lo_rd  <= fw_lo_mem[addr_in];
      fw_len_rd <= fw_len_mem[addr_in];
      fw_pay_rd <= fw_pay_mem[addr_in];
   end

   // range registers
   logic [BucketBits-1:0] rg_b;
   logic rg_ok;
   assign rg_b  = req.slot[BucketBits-1:0];
   assign rg_ok = (req.slot < SlotW'(Buckets));
   logic [SlotW-1:0] rg_last_sat;
   assign rg_last_sat = (32'(req.range_last) > 32'(TABLE_DEPTH - 1))
                        ? SlotW'(TABLE_DEPTH - 1) : req.range_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_pr_ff <= '0;
         fw_pr_ff <= '0;
      end else if (accept && rg_ok) begin
         if (op == OP_RG_EXACT) ex_pr_ff[rg_b] <= req.range_present;
         if (op == OP_RG_FWD)   fw_pr_ff[rg_b] <= req.range_present;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && rg_ok && op == OP_RG_EXACT) begin
         ex_first_ff[rg_b] <= req.range_first;
         ex_last_ff[rg_b]  <= rg_last_sat;
      end
      if (accept && rg_ok && op == OP_RG_FWD) begin
         fw_first_ff[rg_b] <= req.range_first;
         fw_last_ff[rg_b]  <= rg_last_sat;
      end
   end

   // search datapath
   logic [BucketBits-1:0] bkt_new;
   assign bkt_new = bucket_of(khi_m[63:56]);

   // read both ranges of the bucket on the request transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         ex_first_rd <= ex_first_ff[bkt_new];
         ex_last_rd  <= ex_last_ff[bkt_new];
         fw_first_rd <= fw_first_ff[bkt_new];
         fw_last_rd  <= fw_last_ff[bkt_new];
      end
   end

   logic signed [IdxW:0] mid;
   assign mid = lo_ff + ((hi_ff - lo_ff) >>> 1);
   logic signed [IdxW:0] addr_s;
   assign addr_s = $signed((IdxW+1)'(addr_ff));
   logic ex_eq, ex_gt;
   assign ex_eq = (khi_ff == ex_hi_rd) && (klo_ff == ex_lo_rd);
   assign ex_gt = {khi_ff, klo_ff} > {ex_hi_rd, ex_lo_rd};
   logic [4:0] flen, nh, nl;
   assign flen = (fw_len_rd > KeyCh) ? KeyCh : fw_len_rd;
   assign nh   = (flen > 5'd8) ? 5'd8 : flen;
   assign nl   = (flen > 5'd8) ? flen - 5'd8 : 5'd0;
   logic fw_hit;
   assign fw_hit = (((khi_ff ^ fw_hi_rd) & top_bytes(nh)) == '0) &&
                   (((klo_ff ^ fw_lo_rd) & top_bytes(nl)) == '0);

   logic signed [IdxW:0] fw_lo0, fw_hi0;
   assign fw_lo0 = (IdxW+1)'(fw_first_rd);
   assign fw_hi0 = (IdxW+1)'(fw_last_rd);

   always_comb begin
      state_in  = state_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      addr_in   = addr_ff;
      load_rsp  = 1'b0;
      rstat_in  = ST_DONE;
      rentry_in = '0;
      rpay_in   = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (op != OP_LOOKUP) begin
                  load_rsp = 1'b1;
               end else if (!bucket_ok(khi_m[63:56])) begin
                  load_rsp = 1'b1;
                  rstat_in = ST_INVALID;
               end else begin
                  state_in = S_RANGE;
               end
            end
         end
         S_RANGE: begin
            if (ex_pr_ff[bkt_ff]) begin
               lo_in    = (IdxW+1)'(ex_first_rd);
               hi_in    = (IdxW+1)'(ex_last_rd);
               state_in = S_EX_ISSUE;
            end else begin
               state_in = S_FW_ISSUE;
               lo_in    = '0;
               hi_in    = '1;
            end
         end
         S_EX_ISSUE: begin
            if (lo_ff <= hi_ff) begin
               addr_in  = AddrW'(mid);
               state_in = S_EX_CHECK;
            end else begin
               state_in = S_FW_ISSUE;
               lo_in    = '0;
               hi_in    = '1;
            end
         end
         S_EX_CHECK: begin
            if (ex_eq) begin
               state_in  = S_REPLY;
               rstat_in  = ST_EXACT;
               rentry_in = SlotW'(addr_ff);
               rpay_in   = ex_pay_rd;
               load_rsp  = 1'b1;
            end else begin
               if (ex_gt) lo_in = addr_s + IdxOne;
               else       hi_in = addr_s - IdxOne;
               state_in = S_EX_ISSUE;
            end
         end
         S_FW_ISSUE: begin
            // first visit (hi all ones) loads the forward range
            if (hi_ff == '1 && lo_ff == '0) begin
               if (fw_pr_ff[bkt_ff]) begin
                  lo_in = fw_lo0;
                  hi_in = fw_hi0;
                  if (fw_lo0 <= fw_hi0) begin
                     addr_in  = AddrW'(fw_lo0);
                     state_in = S_FW_CHECK;
                  end else begin
                     state_in = S_REPLY;
                     rstat_in = ST_MISS;
                     load_rsp = 1'b1;
                  end
               end else begin
                  state_in = S_REPLY;
                  rstat_in = ST_MISS;
                  load_rsp = 1'b1;
               end
            end else if (lo_ff <= hi_ff) begin
               addr_in  = AddrW'(lo_ff);
               state_in = S_FW_CHECK;
            end else begin
               state_in = S_REPLY;
               rstat_in = ST_MISS;
               load_rsp = 1'b1;
            end
         end
         S_FW_CHECK: begin
            if (fw_hit) begin
               state_in  = S_REPLY;
               rstat_in  = ST_FWD;
               rentry_in = SlotW'(addr_ff);
               rpay_in   = fw_pay_rd;
               load_rsp  = 1'b1;
            end else begin
               lo_in    = lo_ff + IdxOne;
               state_in = S_FW_ISSUE;
            end
         end
         S_REPLY: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_rsp)                      rvalid_ff <= 1'b1;
         else if (rsp.valid && rsp.ready)   rvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      addr_ff <= addr_in;
      if (accept) begin
         khi_ff <= khi_m;
         klo_ff <= klo_m;
         bkt_ff <= bkt_new;
      end
      if (load_rsp) begin
         rstat_ff  <= rstat_in;
         rentry_ff <= rentry_in;
         rpay_ff   <= rpay_in;
      end
   end

   logic rovr;
   assign rovr = rpay_ff[EntW];
   assign rsp.valid          = rvalid_ff;
   assign rsp.status         = rstat_ff;
   assign rsp.entry_found    = rentry_ff;
   assign rsp.entity_found   = rpay_ff[EntW-1:0];
   assign rsp.override_found = rovr;
   assign rsp.override_index = rovr ? rpay_ff[PayW-1:EntW+1] : '0;

   // a new request is never taken while a response waits
   assert property (@(posedge clock) disable iff (reset) rvalid_ff |-> !req.ready)
      else $error("request accepted with response pending");
   // a response appears only from a working state or a direct reply
   assert property (@(posedge clock) disable iff (reset)
      $rose(rvalid_ff) |-> $past(state_ff != S_REPLY))
      else $error("response raised from reply state");
   // a held response keeps its status under stall
   assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> $stable(rsp.status))
      else $error("response changed under stall");
endmodule

FILE: test/tb_top.sv
// Self-checking bench for callsign_prefix_lookup: loads sorted key tables and
// bucket ranges, runs lookups and checks every response. Uses cpl_pkg, cpl_if.
module tb_top;
   import cpl_pkg::*;

   localparam int Depth     = DefTableDepth;
   localparam int WatchDog  = 20000;
   localparam logic [2:0] OP_SPARE_LO = 3'd5;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_A    = 8'h41;

   typedef struct {
      logic [2:0]  op;
      logic [11:0] slot;
      logic [63:0] key_hi;
      logic [63:0] key_lo;
      logic [4:0]  plen;
      logic [9:0]  entity;
      logic        has_ovr;
      logic [9:0]  ovr;
      logic [11:0] first;
      logic [11:0] last;
      logic        present;
   } lookup_req_type;

   typedef struct {
      status_type  status;
      logic [11:0] entry;
      logic [9:0]  entity;
      logic        ovf;
      logic [9:0]  ovr;
   } lookup_rsp_type;

   logic clock;
   logic reset;
   cpl_req_if req_bus ();
   cpl_rsp_if rsp_bus ();

   callsign_prefix_lookup uut (
      .clock(clock),
      .reset(reset),
      .req  (req_bus.sink),
      .rsp  (rsp_bus.source)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // table and range copies held by the predictor
   logic [63:0] ex_hi [Depth];
   logic [63:0] ex_lo [Depth];
   logic [20:0] ex_pay [Depth];
   logic [63:0] fw_hi [Depth];
   logic [63:0] fw_lo [Depth];
   logic [4:0]  fw_len [Depth];
   logic [20:0] fw_pay [Depth];
   logic [11:0] ex_first [Buckets];
   logic [11:0] ex_last [Buckets];
   logic        ex_valid [Buckets];
   logic [11:0] fw_first [Buckets];
   logic [11:0] fw_last [Buckets];
   logic        fw_valid [Buckets];

   // written-entry tracking for stimulus generation
   bit          gen_ex_done [Depth];
   bit          gen_fw_done [Depth];
   int          gen_ex_list [$];
   int          gen_fw_list [$];

   lookup_req_type pending_reqs [$];
   lookup_rsp_type expected_rsps [$];
   int          total_items;
   int          n_accepted;
   int          n_errors;
   int          n_status [5];
   int          quiet_cycles;
   bit          req_took;
   int          send_idle;
   int          recv_idle;

   function automatic logic [63:0] lead_mask(int n);
      if (n <= 0) return 64'h0;
      if (n >= 8) return '1;
      return ~64'h0 << (64 - 8 * n);
   endfunction

   function automatic lookup_rsp_type make_rsp(status_type st, logic [11:0] entry,
                                               logic [20:0] pay);
      lookup_rsp_type r;
      r.status = st;
      r.entry  = entry;
      r.entity = pay[9:0];
      r.ovf    = pay[10];
      r.ovr    = pay[10] ? pay[20:11] : 10'd0;
      return r;
   endfunction

   // update the table copy and work out the one response of an item
   task automatic resolve_item(input lookup_req_type r, output lookup_rsp_type e);
      logic [7:0] ch;
      int         b;
      int         lo;
      int         hi;
      int         mid;
      int         len;
      logic [127:0] key;
      logic [127:0] ent;
      e = make_rsp(ST_DONE, 12'd0, 21'd0);
      case (r.op)
         OP_WR_EXACT: begin
            ex_hi[r.slot]  = r.key_hi;
            ex_lo[r.slot]  = r.key_lo;
            ex_pay[r.slot] = {r.ovr, r.has_ovr, r.entity};
         end
         OP_WR_FWD: begin
            fw_hi[r.slot]  = r.key_hi;
            fw_lo[r.slot]  = r.key_lo;
            fw_len[r.slot] = r.plen;
            fw_pay[r.slot] = {r.ovr, r.has_ovr, r.entity};
         end
         OP_RG_EXACT: begin
            if (r.slot < Buckets) begin
               ex_first[r.slot] = r.first;
               ex_last[r.slot]  = r.last;
               ex_valid[r.slot] = r.present;
            end
         end
         OP_RG_FWD: begin
            if (r.slot < Buckets) begin
               fw_first[r.slot] = r.first;
               fw_last[r.slot]  = r.last;
               fw_valid[r.slot] = r.present;
            end
         end
         OP_LOOKUP: begin
            ch = r.key_hi[63:56];
            if (ch >= CH_ZERO && ch <= CH_ZERO + 8'd9) b = ch - CH_ZERO;
            else if (ch >= CH_A && ch <= CH_A + 8'd25) b = ch - CH_A + 10;
            else begin
               e = make_rsp(ST_INVALID, 12'd0, 21'd0);
               return;
            end
            key = {r.key_hi, r.key_lo};
            if (ex_valid[b]) begin
               lo = ex_first[b];
               hi = ex_last[b];
               while (lo <= hi) begin
                  mid = lo + (hi - lo) / 2;
                  ent = {ex_hi[mid], ex_lo[mid]};
                  if (key == ent) begin
                     e = make_rsp(ST_EXACT, 12'(mid), ex_pay[mid]);
                     return;
                  end
                  if (key > ent) lo = mid + 1;
                  else hi = mid - 1;
               end
            end
            if (fw_valid[b]) begin
               for (int i = fw_first[b]; i <= fw_last[b]; i++) begin
                  len = (fw_len[i] > 16) ? 16 : fw_len[i];
                  if (((r.key_hi ^ fw_hi[i]) & lead_mask(len)) == 0 &&
                      ((r.key_lo ^ fw_lo[i]) & lead_mask(len - 8)) == 0) begin
                     e = make_rsp(ST_FWD, 12'(i), fw_pay[i]);
                     return;
                  end
               end
            end
            e = make_rsp(ST_MISS, 12'd0, 21'd0);
         end
         default: ;
      endcase
   endtask

   function automatic lookup_req_type random_req(logic [2:0] op);
      lookup_req_type r;
      r.op      = op;
      r.slot    = 12'($urandom);
      r.key_hi  = {$urandom, $urandom};
      r.key_lo  = {$urandom, $urandom};
      r.plen    = 5'($urandom);
      r.entity  = 10'($urandom);
      r.has_ovr = 1'($urandom);
      r.ovr     = 10'($urandom);
      r.first   = 12'($urandom);
      r.last    = 12'($urandom);
      r.present = 1'($urandom);
      return r;
   endfunction

   function automatic logic [7:0] bucket_char(int b);
      return (b < 10) ? CH_ZERO + 8'(b) : CH_A + 8'(b - 10);
   endfunction

   task automatic add_write(logic [2:0] op, int addr, logic [127:0] key, int len);
      lookup_req_type r;
      r = random_req(op);
      r.slot   = 12'(addr);
      r.key_hi = key[127:64];
      r.key_lo = key[63:0];
      r.plen   = 5'(len);
      if (op == OP_WR_EXACT) begin
         if (!gen_ex_done[addr]) gen_ex_list.push_back(addr);
         gen_ex_done[addr] = 1'b1;
      end else begin
         if (!gen_fw_done[addr]) gen_fw_list.push_back(addr);
         gen_fw_done[addr] = 1'b1;
      end
      pending_reqs.push_back(r);
   endtask

   task automatic add_range(logic [2:0] op, int bucket, int first, int last, bit present);
      lookup_req_type r;
      r = random_req(op);
      r.slot    = 12'(bucket);
      r.first   = 12'(first);
      r.last    = 12'(last);
      r.present = present;
      pending_reqs.push_back(r);
   endtask

   task automatic add_lookup(logic [127:0] key);
      lookup_req_type r;
      r = random_req(OP_LOOKUP);
      r.key_hi = key[127:64];
      r.key_lo = key[63:0];
      pending_reqs.push_back(r);
   endtask

   // well-formed load of one bucket followed by lookups against it
   task automatic add_bucket_set(int b, int ex_base, int n_ex, int fw_base, int n_fw);
      logic [127:0] ex_keys [$];
      logic [127:0] fw_keys [$];
      int           fw_lens [$];
      logic [127:0] k;
      logic [127:0] m;
      logic [7:0]   c;
      int           len;
      int           kind;
      int           idx;
      c = bucket_char(b);
      for (int i = 0; i < n_ex; i++) begin
         k = {c, 24'($urandom), {$urandom, $urandom, $urandom}};
         if ($urandom_range(1)) k[63:0] = '0;
         ex_keys.push_back(k);
      end
      ex_keys.sort();
      for (int i = 0; i < n_ex; i++) add_write(OP_WR_EXACT, ex_base + i, ex_keys[i], 0);
      for (int i = 0; i < n_fw; i++) begin
         len = ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(1, 6);
         k = {c, 24'($urandom), {$urandom, $urandom, $urandom}};
         fw_keys.push_back(k);
         fw_lens.push_back(len);
         add_write(OP_WR_FWD, fw_base + i, k, len);
      end
      add_range(OP_RG_EXACT, b, ex_base, ex_base + n_ex - 1, n_ex > 0);
      add_range(OP_RG_FWD, b, fw_base, fw_base + n_fw - 1, n_fw > 0);
      repeat ($urandom_range(4, 8)) begin
         kind = $urandom_range(3);
         k = {c, 24'($urandom), {$urandom, $urandom, $urandom}};
         if (kind == 0 && n_ex > 0) begin
            k = ex_keys[$urandom_range(n_ex - 1)];
         end else if (kind == 1 && n_fw > 0) begin
            idx = $urandom_range(n_fw - 1);
            len = (fw_lens[idx] > 16) ? 16 : fw_lens[idx];
            m = (len == 0) ? '0 : ~128'h0 << (128 - 8 * len);
            k = (fw_keys[idx] & m) | (k & ~m);
            k[127:120] = c;
         end else if (kind == 3 && n_ex > 0) begin
            k = ex_keys[$urandom_range(n_ex - 1)];
            k[8 * $urandom_range(14) +: 8] ^= 8'($urandom_range(1, 255));
         end
         add_lookup(k);
      end
   endtask

   task automatic add_noise();
      lookup_req_type r;
      int          mode;
      int          a;
      mode = $urandom_range(9);
      r = random_req(OP_LOOKUP);
      case (mode)
         0: add_write(OP_WR_EXACT, $urandom_range(Depth - 1), {r.key_hi, r.key_lo}, 0);
         1: add_write(OP_WR_FWD, $urandom_range(Depth - 1), {r.key_hi, r.key_lo}, r.plen);
         2, 3: begin
            r.op = $urandom_range(1) ? OP_RG_EXACT : OP_RG_FWD;
            r.slot = ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(35));
            if (r.slot < Buckets) begin
               a = $urandom_range(2);
               if (a == 0) r.present = 1'b0;
               else if (a == 1) begin
                  r.first = 12'($urandom_range(1, Depth - 1));
                  r.last  = 12'($urandom_range(r.first - 1));
               end else if (r.op == OP_RG_EXACT && gen_ex_list.size() > 0) begin
                  r.first = 12'(gen_ex_list[$urandom_range(gen_ex_list.size() - 1)]);
                  r.last  = r.first;
               end else if (r.op == OP_RG_FWD && gen_fw_list.size() > 0) begin
                  r.first = 12'(gen_fw_list[$urandom_range(gen_fw_list.size() - 1)]);
                  r.last  = r.first;
               end else r.present = 1'b0;
            end
            pending_reqs.push_back(r);
         end
         4: begin
            r.op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
            pending_reqs.push_back(r);
         end
         5, 6: begin
            r.key_hi[63:56] = bucket_char($urandom_range(35));
            pending_reqs.push_back(r);
         end
         default: pending_reqs.push_back(r);
      endcase
   endtask

   task automatic report_mismatch(string field, int got, int want);
      $display("tb_top: mismatch on %s at response %0d: got %0d, expected %0d",
               field, n_status[0] + n_status[1] + n_status[2] + n_status[3] + n_status[4],
               got, want);
      n_errors++;
   endtask

   initial begin
      lookup_req_type r;
      int          b;
      int          base;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.op = OP_LOOKUP;
      req_bus.slot = '0;
      req_bus.key_hi = '0;
      req_bus.key_lo = '0;
      req_bus.prefix_length = '0;
      req_bus.entity_number = '0;
      req_bus.has_override = 1'b0;
      req_bus.override_number = '0;
      req_bus.range_first = '0;
      req_bus.range_last = '0;
      req_bus.range_present = 1'b0;
      rsp_bus.ready = 1'b0;
      for (int i = 0; i < Buckets; i++) begin
         ex_valid[i] = 1'b0;
         fw_valid[i] = 1'b0;
      end

      // directed: empty buckets, every invalid boundary, ignored writes, table ends
      add_lookup({CH_A + 8'd16, 120'h0});
      add_lookup({8'h00, 120'h0});
      add_lookup({8'h2F, 120'h1});
      add_lookup({8'h3A, 120'h0});
      add_lookup({8'h40, 120'h0});
      add_lookup({8'h5B, 120'h0});
      add_lookup({8'hFF, {15{8'hFF}}});
      add_write(OP_WR_EXACT, 0, {CH_ZERO, {15{8'hFF}}}, 0);
      add_range(OP_RG_EXACT, 0, 0, 0, 1'b1);
      add_lookup({CH_ZERO, {15{8'hFF}}});
      add_write(OP_WR_FWD, Depth - 1, {CH_A + 8'd25, 120'h0}, 0);
      add_range(OP_RG_FWD, 35, Depth - 1, Depth - 1, 1'b1);
      add_lookup({CH_A + 8'd25, {15{8'hA5}}});
      add_range(OP_RG_EXACT, 36, 0, Depth - 1, 1'b1);
      add_range(OP_RG_FWD, 4095, 0, Depth - 1, 1'b1);
      r = random_req(OP_SPARE_LO);
      pending_reqs.push_back(r);
      r = random_req(OP_SPARE_HI);
      pending_reqs.push_back(r);
      add_write(OP_WR_FWD, Depth - 2, {CH_ZERO + 8'd9, {15{8'h5A}}}, 31);
      add_range(OP_RG_FWD, 9, Depth - 2, Depth - 2, 1'b1);
      add_lookup({CH_ZERO + 8'd9, {15{8'h5A}}});
      add_lookup({CH_ZERO + 8'd9, {14{8'h5A}}, 8'h5B});
      // top of the table for the last bucket
      add_bucket_set(35, Depth - 6, 6, Depth - 9, 3);

      while (pending_reqs.size() < 450) begin
         if ($urandom_range(9) < 7) begin
            b = $urandom_range(35);
            base = $urandom_range(Depth - 40);
            add_bucket_set(b, base, $urandom_range(0, 16), base + 20, $urandom_range(0, 8));
         end else begin
            repeat ($urandom_range(1, 6)) add_noise();
         end
      end
      total_items = pending_reqs.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      while (n_accepted < total_items || expected_rsps.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("tb_top: %0d items, %0d writes or spare ops, %0d exact, %0d forward,",
               total_items, n_status[0], n_status[1], n_status[2]);
      $display("tb_top: %0d misses, %0d invalid first characters, %0d mismatches",
               n_status[3], n_status[4], n_errors);
      if (n_errors == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

   always @(negedge clock) begin : drive_req
      lookup_req_type nx;
      if (n_accepted < total_items / 3) begin
         send_idle = 23;
         recv_idle = 84;
      end else if (n_accepted < 2 * total_items / 3) begin
         send_idle = 84;
         recv_idle = 23;
      end else begin
         send_idle = 0;
         recv_idle = 0;
      end
      if (!reset) begin
         if (!req_bus.valid || req_took) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
               nx = pending_reqs.pop_front();
               req_bus.op <= nx.op;
               req_bus.slot <= nx.slot;
               req_bus.key_hi <= nx.key_hi;
               req_bus.key_lo <= nx.key_lo;
               req_bus.prefix_length <= nx.plen;
               req_bus.entity_number <= nx.entity;
               req_bus.has_override <= nx.has_ovr;
               req_bus.override_number <= nx.ovr;
               req_bus.range_first <= nx.first;
               req_bus.range_last <= nx.last;
               req_bus.range_present <= nx.present;
               req_bus.valid <= 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   always @(posedge clock) begin : watch_bus
      lookup_req_type r;
      lookup_rsp_type e;
      req_took <= req_bus.valid && req_bus.ready && !reset;
      if (!reset && req_bus.valid && req_bus.ready) begin
         r.op = req_bus.op;
         r.slot = req_bus.slot;
         r.key_hi = req_bus.key_hi;
         r.key_lo = req_bus.key_lo;
         r.plen = req_bus.prefix_length;
         r.entity = req_bus.entity_number;
         r.has_ovr = req_bus.has_override;
         r.ovr = req_bus.override_number;
         r.first = req_bus.range_first;
         r.last = req_bus.range_last;
         r.present = req_bus.range_present;
         resolve_item(r, e);
         expected_rsps.push_back(e);
         n_accepted++;
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_rsps.size() == 0) begin
            $display("tb_top: response transfer with nothing outstanding");
            n_errors++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_bus.status != e.status)
               report_mismatch("status", rsp_bus.status, e.status);
            if (rsp_bus.entry_found != e.entry)
               report_mismatch("entry_found", rsp_bus.entry_found, e.entry);
            if (rsp_bus.entity_found != e.entity)
               report_mismatch("entity_found", rsp_bus.entity_found, e.entity);
            if (rsp_bus.override_found != e.ovf)
               report_mismatch("override_found", rsp_bus.override_found, e.ovf);
            if (rsp_bus.override_index != e.ovr)
               report_mismatch("override_index", rsp_bus.override_index, e.ovr);
            if (e.status <= ST_INVALID) n_status[e.status]++;
         end
      end
      // hold the count down while anything moves
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchDog) begin
         $display("tb_top: no transfer for %0d cycles", WatchDog);
         $display("tb_top: FAIL");
         $finish;
      end
   end

endmodule

FILE: files.f
src/cpl_pkg.sv
src/cpl_if.sv
src/callsign_prefix_lookup.sv
test/tb_top.sv
